// ===== design/asta_pkg.sv =====
`default_nettype none

package asta_pkg;

   localparam int FractionBitsDefault = 16;

   localparam int CfgW    = 13;
   localparam int ColW    = 16;
   localparam int RowW    = 12;
   localparam int CoordW  = 32;
   localparam int IdxW    = 24;
   localparam int CsrIdxW = 2;

   // signed column math needs one bit more than a column
   localparam int ColExtW  = ColW + 1;
   // span width is 1 .. 2^ColW
   localparam int WidthW   = ColW + 1;
   // coordinate delta, one bit more than a coordinate
   localparam int DeltaW   = CoordW + 1;
   localparam int DivSteps = DeltaW;
   localparam int DivCntW  = $clog2(DivSteps);

   localparam logic [CsrIdxW-1:0] RegClipStart   = 2'd0;
   localparam logic [CsrIdxW-1:0] RegClipEnd     = 2'd1;
   localparam logic [CsrIdxW-1:0] RegScreenWidth = 2'd2;
   localparam logic [CsrIdxW-1:0] RegSpriteWidth = 2'd3;

   localparam logic [CfgW-1:0] ClipStartReset   = 13'd0;
   localparam logic [CfgW-1:0] ClipEndReset     = 13'd320;
   localparam logic [CfgW-1:0] ScreenWidthReset = 13'd320;
   localparam logic [CfgW-1:0] SpriteWidthReset = 13'd16;

   localparam logic CmdBegin = 1'b0;
   localparam logic CmdPixel = 1'b1;

   typedef struct packed {
      logic [CfgW-1:0] clip_start_col;
      logic [CfgW-1:0] clip_end_col;
      logic [CfgW-1:0] screen_width;
      logic [CfgW-1:0] sprite_width;
   } cfg_type;

   typedef struct packed {
      logic begin_load;
      logic pixel_take;
      logic div_start;
      logic step_load;
      logic mul_load;
      logic prestep_add;
   } dp_cmd_type;

   typedef struct packed {
      logic span_keep;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/affine_span_texel_addresser.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  cmd, row, left/right col, left/right u, v
// rsp_      out        rsp_valid/rsp_ready  pixel_valid, dest_index, texel_index, span_last
// csr_      in         csr_wen              csr_index, csr_wdata
//
// Pixel transactions stream one per cycle through a single output register
// unless a span is set up or rsp_ready stalls. A culled begin only loads the
// span; a live span runs the 33-step radix-2 step divider, pre-step mul, add.
// reset is synchronous; it clears the span and restores the register defaults.
// req_ready drops while a span is set up or while a result waits on rsp_ready.

module affine_span_texel_addresser
   import asta_pkg::*;
#(
   parameter int FRACTION_BITS = FractionBitsDefault
)
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_cmd,
   input  wire logic [RowW-1:0]     req_row,
   input  wire logic [ColW-1:0]     req_left_col,
   input  wire logic [ColW-1:0]     req_right_col,
   input  wire logic [CoordW-1:0]   req_left_u,
   input  wire logic [CoordW-1:0]   req_left_v,
   input  wire logic [CoordW-1:0]   req_right_u,
   input  wire logic [CoordW-1:0]   req_right_v,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_pixel_valid,
   output logic [IdxW-1:0]          rsp_dest_index,
   output logic [IdxW-1:0]          rsp_texel_index,
   output logic                     rsp_span_last,

   input  wire logic                csr_wen,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CfgW-1:0]     csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    cmd;
   dp_status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            RegClipStart:   cfg_in.clip_start_col = csr_wdata;
            RegClipEnd:     cfg_in.clip_end_col   = csr_wdata;
            RegScreenWidth: cfg_in.screen_width   = csr_wdata;
            RegSpriteWidth: cfg_in.sprite_width   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_start_col <= ClipStartReset;
         cfg_ff.clip_end_col   <= ClipEndReset;
         cfg_ff.screen_width   <= ScreenWidthReset;
         cfg_ff.sprite_width   <= SpriteWidthReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   asta_dp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg             (cfg_ff),
      .req_row         (req_row),
      .req_left_col    (req_left_col),
      .req_right_col   (req_right_col),
      .req_left_u      (req_left_u),
      .req_left_v      (req_left_v),
      .req_right_u     (req_right_u),
      .req_right_v     (req_right_v),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_texel_index (rsp_texel_index),
      .rsp_span_last   (rsp_span_last)
   );

endmodule

`default_nettype wire

// ===== design/asta_div.sv =====
`default_nettype none

// Radix-2 restoring divider: signed delta, nudged away from zero, over a
// positive divisor, truncating toward zero. One quotient bit per cycle.
module asta_div
   import asta_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [DeltaW-1:0]        delta,
   input  wire logic [WidthW-1:0]        divisor,
   output logic                          done,
   output logic [CoordW-1:0]             quotient
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivCntW-1:0]  cnt_ff, cnt_in;
   logic [DeltaW-1:0]   mag_ff, mag_in;
   logic [WidthW-1:0]   rem_ff, rem_in;
   logic                neg_ff, neg_in;

   logic                delta_neg;
   logic [DeltaW-1:0]   opnd;
   logic [DeltaW-1:0]   inc;
   logic [DeltaW-1:0]   mag_load;
   logic [WidthW:0]     trial;
   logic [WidthW:0]     diff;
   logic                ge;

   // |d| + 1 for nonzero d; for negative d that is ~d + 2
   assign delta_neg = delta[DeltaW-1];
   assign opnd      = delta_neg ? ~delta : delta;
   assign inc       = delta_neg ? DeltaW'(2) : DeltaW'(|delta);
   assign mag_load  = opnd + inc;

   assign trial = {rem_ff, mag_ff[DeltaW-1]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mag_in  = mag_load;
         rem_in  = '0;
         neg_in  = delta_neg;
      end else if (busy_ff) begin
         rem_in = ge ? diff[WidthW-1:0] : trial[WidthW-1:0];
         mag_in = {mag_ff[DeltaW-2:0], ge};
         cnt_in = cnt_ff + DivCntW'(1);
         if (cnt_ff == DivCntW'(DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~mag_ff[CoordW-1:0] + CoordW'(1)) : mag_ff[CoordW-1:0];

endmodule

`default_nettype wire

// ===== design/asta_dp.sv =====
`default_nettype none

module asta_dp
   import asta_pkg::*;
#(
   parameter int FRACTION_BITS = FractionBitsDefault
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_status_type            status,
   input  wire cfg_type             cfg,
   input  wire logic [RowW-1:0]     req_row,
   input  wire logic [ColW-1:0]     req_left_col,
   input  wire logic [ColW-1:0]     req_right_col,
   input  wire logic [CoordW-1:0]   req_left_u,
   input  wire logic [CoordW-1:0]   req_left_v,
   input  wire logic [CoordW-1:0]   req_right_u,
   input  wire logic [CoordW-1:0]   req_right_v,
   output logic                     rsp_pixel_valid,
   output logic [IdxW-1:0]          rsp_dest_index,
   output logic [IdxW-1:0]          rsp_texel_index,
   output logic                     rsp_span_last
);

   // span state
   logic                span_active_ff;
   logic [ColW-1:0]     cur_col_ff;
   logic [ColW-1:0]     end_col_ff;
   logic [IdxW-1:0]     row_base_ff;
   logic [CoordW-1:0]   cur_u_ff;
   logic [CoordW-1:0]   cur_v_ff;
   logic [CoordW-1:0]   step_u_ff;
   logic [CoordW-1:0]   step_v_ff;

   // setup scratch
   logic [WidthW-1:0]   width_ff;
   logic [ColW-1:0]     pre_n_ff;
   logic [DeltaW-1:0]   delta_u_ff;
   logic [DeltaW-1:0]   delta_v_ff;
   logic [CoordW-1:0]   prod_u_ff;
   logic [CoordW-1:0]   prod_v_ff;

   // result register
   logic                rsp_pixel_valid_ff;
   logic [IdxW-1:0]     rsp_dest_index_ff;
   logic [IdxW-1:0]     rsp_texel_index_ff;
   logic                rsp_span_last_ff;

   logic signed [ColExtW-1:0] x0, x1, cs, ce, ce_m1, x0c, x1c, pre_diff;
   logic                      culled;
   logic [WidthW-1:0]         span_w;
   logic [DeltaW-1:0]         delta_u, delta_v;
   logic [RowW+CfgW-1:0]      row_prod;
   logic [CoordW-1:0]         q_u, q_v;
   logic                      done_u, done_v;
   logic [CoordW+ColW-1:0]    mul_u, mul_v;

   logic signed [CoordW-1:0]  iu_full, iv_full;
   logic [IdxW+CfgW-1:0]      tex_prod;
   logic [IdxW-1:0]           tex_idx;
   logic [IdxW-1:0]           dest_idx;
   logic                      is_last;

   assign x0    = $signed({req_left_col[ColW-1], req_left_col});
   assign x1    = $signed({req_right_col[ColW-1], req_right_col});
   assign cs    = $signed(ColExtW'(cfg.clip_start_col));
   assign ce    = $signed(ColExtW'(cfg.clip_end_col));
   assign ce_m1 = ce - ColExtW'(1);

   assign culled   = (x1 < x0) || (x0 >= ce) || (x1 < cs);
   assign x0c      = (x0 < cs) ? cs : x0;
   assign x1c      = (x1 >= ce) ? ce_m1 : x1;
   assign pre_diff = cs - x0;
   assign span_w   = WidthW'(x1 - x0 + ColExtW'(1));

   assign status.span_keep = !culled && !(x0c > x1c);
   assign status.div_done  = done_u;

   assign delta_u  = {req_right_u[CoordW-1], req_right_u} - {req_left_u[CoordW-1], req_left_u};
   assign delta_v  = {req_right_v[CoordW-1], req_right_v} - {req_left_v[CoordW-1], req_left_v};
   assign row_prod = req_row * cfg.screen_width;

   asta_div u_div_u (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .delta    (delta_u_ff),
      .divisor  (width_ff),
      .done     (done_u),
      .quotient (q_u)
   );

   asta_div u_div_v (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .delta    (delta_v_ff),
      .divisor  (width_ff),
      .done     (done_v),
      .quotient (q_v)
   );

   assign mul_u = step_u_ff * pre_n_ff;
   assign mul_v = step_v_ff * pre_n_ff;

   // texel lookup: floor of the fixed-point coordinates, wrapped to index width
   assign iu_full  = $signed(cur_u_ff) >>> FRACTION_BITS;
   assign iv_full  = $signed(cur_v_ff) >>> FRACTION_BITS;
   assign tex_prod = iv_full[IdxW-1:0] * cfg.sprite_width;
   assign tex_idx  = tex_prod[IdxW-1:0] + iu_full[IdxW-1:0];
   assign dest_idx = row_base_ff + IdxW'(cur_col_ff);
   assign is_last  = (cur_col_ff == end_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         span_active_ff <= 1'b0;
      end else if (cmd.begin_load) begin
         span_active_ff <= 1'b0;
      end else if (cmd.prestep_add) begin
         span_active_ff <= 1'b1;
      end else if (cmd.pixel_take && span_active_ff && is_last) begin
         span_active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.begin_load) begin
         cur_col_ff  <= x0c[ColW-1:0];
         end_col_ff  <= x1c[ColW-1:0];
         width_ff    <= span_w;
         pre_n_ff    <= (x0 < cs) ? pre_diff[ColW-1:0] : '0;
         delta_u_ff  <= delta_u;
         delta_v_ff  <= delta_v;
         cur_u_ff    <= req_left_u;
         cur_v_ff    <= req_left_v;
         row_base_ff <= row_prod[IdxW-1:0];
      end else if (cmd.prestep_add) begin
         cur_u_ff <= cur_u_ff + prod_u_ff;
         cur_v_ff <= cur_v_ff + prod_v_ff;
      end else if (cmd.pixel_take && span_active_ff && !is_last) begin
         cur_col_ff <= cur_col_ff + ColW'(1);
         cur_u_ff   <= cur_u_ff + step_u_ff;
         cur_v_ff   <= cur_v_ff + step_v_ff;
      end

      // both dividers run in lockstep
      if (cmd.step_load && done_v) begin
         step_u_ff <= q_u;
         step_v_ff <= q_v;
      end

      if (cmd.mul_load) begin
         prod_u_ff <= mul_u[CoordW-1:0];
         prod_v_ff <= mul_v[CoordW-1:0];
      end

      if (cmd.pixel_take) begin
         rsp_pixel_valid_ff <= span_active_ff;
         rsp_dest_index_ff  <= span_active_ff ? dest_idx : '0;
         rsp_texel_index_ff <= span_active_ff ? tex_idx : '0;
         rsp_span_last_ff   <= span_active_ff && is_last;
      end
   end

   assign rsp_pixel_valid = rsp_pixel_valid_ff;
   assign rsp_dest_index  = rsp_dest_index_ff;
   assign rsp_texel_index = rsp_texel_index_ff;
   assign rsp_span_last   = rsp_span_last_ff;

endmodule

`default_nettype wire

// ===== design/asta_ctrl.sv =====
`default_nettype none

module asta_ctrl
   import asta_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_cmd,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire dp_status_type  status,
   output dp_cmd_type          cmd
);

   typedef enum logic [4:0] {
      StIdle     = 5'b00001,
      StDivStart = 5'b00010,
      StDiv      = 5'b00100,
      StMul      = 5'b01000,
      StAdd      = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      take_begin;
   logic      take_pixel;

   // output register must be free (or draining) before a new transaction
   assign req_ready  = (state_ff == StIdle) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign take_begin = accept && (req_cmd == CmdBegin);
   assign take_pixel = accept && (req_cmd == CmdPixel);

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.begin_load  = take_begin;
      cmd.pixel_take  = take_pixel;
      unique case (state_ff)
         StIdle: begin
            if (take_begin && status.span_keep) begin
               state_in = StDivStart;
            end
         end
         StDivStart: begin
            cmd.div_start = 1'b1;
            state_in      = StDiv;
         end
         StDiv: begin
            if (status.div_done) begin
               cmd.step_load = 1'b1;
               state_in      = StMul;
            end
         end
         StMul: begin
            cmd.mul_load = 1'b1;
            state_in     = StAdd;
         end
         StAdd: begin
            cmd.prestep_add = 1'b1;
            state_in        = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      if (take_pixel) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
